>>> hdl/bf3_pkg.sv
// ---------------------------------------------------------------------------
// bf3_pkg
// shared types, constants and the divide-by-nine helper of the 3x3 box filter
// ---------------------------------------------------------------------------
package bf3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    // one window column of original pixels
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } t_column;

    // sum of nine 8-bit pixels fits in 12 bits
    localparam int SUM_W = 12;

    // ceil(2^16 / 9), exact for every sum below 32768
    localparam logic [12:0] DIV9_RECIP = 13'd7282;

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] x);
        logic [24:0] prod;
        prod = 25'(x) * 25'(DIV9_RECIP);
        return prod[23:16];
    endfunction

endpackage

>>> hdl/bf3_mean.sv
// ---------------------------------------------------------------------------
// bf3_mean
// floor of the mean of a 3x3 window given as three columns
// ---------------------------------------------------------------------------
module bf3_mean (
    input  bf3_pkg::t_column i_col_cur,
    input  bf3_pkg::t_column i_col_prev,
    input  bf3_pkg::t_column i_col_prev2,
    output logic [7:0]       o_mean
);

    logic [bf3_pkg::SUM_W-1:0] sum;

    always_comb begin
        sum = bf3_pkg::SUM_W'(i_col_cur.top)   + bf3_pkg::SUM_W'(i_col_cur.mid)
            + bf3_pkg::SUM_W'(i_col_cur.bot)   + bf3_pkg::SUM_W'(i_col_prev.top)
            + bf3_pkg::SUM_W'(i_col_prev.mid)  + bf3_pkg::SUM_W'(i_col_prev.bot)
            + bf3_pkg::SUM_W'(i_col_prev2.top) + bf3_pkg::SUM_W'(i_col_prev2.mid)
            + bf3_pkg::SUM_W'(i_col_prev2.bot);
        o_mean = bf3_pkg::div9(sum);
    end

endmodule

>>> hdl/box_filter_3x3.sv
// ---------------------------------------------------------------------------
// box_filter_3x3
// streaming 3x3 mean filter over a raster pixel stream, borders passed through
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_pixel_value
//  out     | out of    | o_out_valid / i_out_stall  | o_out_row o_out_col o_out_value
//          |           |                            | o_last_of_run
//  cfg     | into      | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
//  one pixel per clock sustained while the result queue has room: the line buffer read happens at the input
//  transaction, the sum and divide run in the following cycle
//  an input transaction passes through stage 1 and then the result queue before its first result is offered
//  a pixel giving two results (interior plus border) costs an extra output
//  transaction, set by the single-result output port and the two-entry result queue
//  reset clears counters, window and queue; line buffers are not cleared
//  a stall on the output backs up into the pipeline stage, then into o_in_stall
//
module box_filter_3x3 #(
    parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bf3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_pixel_value,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [9:0]                     o_out_row,
    output logic [9:0]                     o_out_col,
    output logic [7:0]                     o_out_value,
    output logic                           o_last_of_run,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // widths of sizes (up to max) and of positions (below max)
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] value;
        logic       last;
    } t_result;

    // configuration registers
    logic [bf3_pkg::CFG_DATA_W-1:0] r_cfg_width, r_cfg_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bf3_pkg::CFG_SIZE_RESET;
            r_cfg_height <= bf3_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bf3_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                bf3_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, anything above the max acts as the max
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        if (r_cfg_width == '0)
            w_eff = WW'(1);
        else if (32'(r_cfg_width) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(r_cfg_width);

        if (r_cfg_height == '0)
            h_eff = HW'(1);
        else if (32'(r_cfg_height) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(r_cfg_height);
    end

    // position of the next pixel
    logic [CW-1:0] r_col, n_col, c_use;
    logic [RW-1:0] r_row, n_row, r_use;
    logic          in_accept;
    logic          pos_interior, pos_border;

    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        // restart a counter that a smaller size left out of range
        c_use = (32'(r_col) >= 32'(w_eff)) ? '0 : r_col;
        r_use = (32'(r_row) >= 32'(h_eff)) ? '0 : r_row;

        pos_interior = (32'(r_use) >= 32'd2) && (32'(c_use) >= 32'd2);
        pos_border   = (r_use == '0) || (32'(r_use) == 32'(h_eff) - 32'd1)
                    || (c_use == '0) || (32'(c_use) == 32'(w_eff) - 32'd1);

        n_col = CW'(32'(c_use) + 32'd1);
        n_row = r_use;
        if (32'(c_use) + 32'd1 >= 32'(w_eff)) begin
            n_col = '0;
            n_row = (32'(r_use) + 32'd1 >= 32'(h_eff)) ? '0 : RW'(32'(r_use) + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffers, read at the input transaction and written when the pixel leaves stage 1
    logic [7:0] r_line_above     [MAX_WIDTH];
    logic [7:0] r_line_two_above [MAX_WIDTH];
    logic [7:0] r_rd_mid, r_rd_top;

    // stage 1 holds one pixel with its window column data
    logic          r_s1_valid;
    logic [7:0]    r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_interior, r_s1_border;
    logic          s1_fire;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_mid <= r_line_above[c_use];
            r_rd_top <= r_line_two_above[c_use];
        end
        if (s1_fire) begin
            r_line_above[r_s1_col]     <= r_s1_pix;
            r_line_two_above[r_s1_col] <= r_rd_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix      <= i_pixel_value;
            r_s1_col      <= c_use;
            r_s1_row      <= r_use;
            r_s1_interior <= pos_interior;
            r_s1_border   <= pos_border;
        end
    end

    // sliding window of the two previous columns
    bf3_pkg::t_column r_win0, r_win1, col_cur;

    assign col_cur = '{top: r_rd_top, mid: r_rd_mid, bot: r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (s1_fire) begin
            r_win1 <= r_win0;
            r_win0 <= col_cur;
        end
    end

    logic [7:0] mean;

    bf3_mean u_mean (
        .i_col_cur   (col_cur),
        .i_col_prev  (r_win0),
        .i_col_prev2 (r_win1),
        .o_mean      (mean)
    );

    // two-entry result queue; head is slot 0
    t_result    r_q0, r_q1, n_q0, n_q1;
    t_result    res_int, res_bord, res_first;
    logic [1:0] r_q_cnt, n_q_cnt, base, n_res;
    logic       pop;

    always_comb begin
        res_int.row   = 10'(32'(r_s1_row) - 32'd1);
        res_int.col   = 10'(32'(r_s1_col) - 32'd1);
        res_int.value = mean;
        res_int.last  = !r_s1_border;

        res_bord.row   = 10'(r_s1_row);
        res_bord.col   = 10'(r_s1_col);
        res_bord.value = r_s1_pix;
        res_bord.last  = 1'b1;

        res_first = r_s1_interior ? res_int : res_bord;

        pop     = (r_q_cnt != 2'd0) && !i_out_stall;
        base    = r_q_cnt - 2'(pop);
        n_res   = 2'(r_s1_interior) + 2'(r_s1_border);
        // fire only when every result of the pixel finds a free slot
        s1_fire = r_s1_valid && (3'(base) + 3'(n_res) <= 3'd2);

        n_q0 = pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (s1_fire) begin
            if (base == 2'd0) begin
                if (n_res != 2'd0) n_q0 = res_first;
                if (n_res == 2'd2) n_q1 = res_bord;
            end else if (base == 2'd1) begin
                if (n_res != 2'd0) n_q1 = res_first;
            end
        end
        n_q_cnt = base + (s1_fire ? n_res : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    // input stalls while stage 1 holds a pixel that cannot move on
    assign o_in_stall = r_s1_valid && !s1_fire;

    assign o_out_valid   = (r_q_cnt != 2'd0);
    assign o_out_row     = r_q0.row;
    assign o_out_col     = r_q0.col;
    assign o_out_value   = r_q0.value;
    assign o_last_of_run = r_q0.last;

endmodule

>>> hdl/bf3_checker.sv
// ---------------------------------------------------------------------------
// bf3_checker
// port-level checks of the 3x3 box filter, bound to the top level
// ---------------------------------------------------------------------------
module bf3_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [9:0] o_out_row,
    input logic [9:0] o_out_col,
    input logic [7:0] o_out_value,
    input logic       o_last_of_run
);

    // a stalled result transaction stays offered
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // and its payload holds
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_row) && $stable(o_out_col)
            && $stable(o_out_value) && $stable(o_last_of_run))
        else $error("stalled result payload changed");

    // input only backs up when results are waiting
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result queue");

    // reset empties the result queue
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind box_filter_3x3 bf3_checker u_bf3_checker (.*);
